### src/crtb_pkg.sv
package crtb_pkg;

  localparam int TIMER_SLOTS = 4;
  localparam int NUM_TIMERS_DEF = 4;
  localparam int COUNT_W = 16;
  localparam int PRESCALE_W = 10;
  localparam int SEL_W = 2;
  localparam int NIBBLE_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W = 8;
  localparam int OUT_W = 2 * TIMER_SLOTS + TIMER_SLOTS * COUNT_W;

  // nibble layout
  localparam int NIB_CASCADE = 2;
  localparam int NIB_START = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // prescale periods 1, 64, 256, 1024
  localparam logic [PRESCALE_W-1:0] PERIOD_MASK [2**SEL_W] = '{
    10'd0, 10'd63, 10'd255, 10'd1023
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELOAD_ZERO   = 3'd0,
    REG_RELOAD_ONE    = 3'd1,
    REG_RELOAD_TWO    = 3'd2,
    REG_RELOAD_THREE  = 3'd3,
    REG_TIMER_CONTROL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                ld_reload;
    logic                ld_ctrl;
    logic [COUNT_W-1:0]  data;
  } cell_cfg_t;

  typedef struct packed {
    logic                  step;
    logic                  ime;
    logic [2**SEL_W-1:0]   hit;
  } cell_ctl_t;

endpackage

### src/crtb_cell.sv
module crtb_cell #(
  parameter bit CASCADE_EN = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  crtb_pkg::cell_cfg_t           cfg,
  input  crtb_pkg::cell_ctl_t           ctl,
  input  logic                          carry_in,
  output logic                          carry_out,
  output logic                          irq,
  output logic [crtb_pkg::COUNT_W-1:0]  count_next
);

  logic [crtb_pkg::COUNT_W-1:0]  count;
  logic [crtb_pkg::COUNT_W-1:0]  reload;
  logic [crtb_pkg::NIBBLE_W-1:0] nibble;
  logic                          cascade;
  logic                          inc;

  assign cascade = CASCADE_EN && nibble[crtb_pkg::NIB_CASCADE];

  always_comb begin
    inc = 1'b0;
    if (ctl.step && nibble[crtb_pkg::NIB_START]) begin
      if (cascade) begin
        inc = carry_in;
      end else begin
        inc = ctl.hit[nibble[crtb_pkg::SEL_W-1:0]];
      end
    end
  end

  assign carry_out = inc && (count == crtb_pkg::COUNT_MAX);
  assign irq = carry_out && ctl.ime;

  always_comb begin
    count_next = count;
    if (inc) begin
      count_next = carry_out ? reload : count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      reload <= '0;
      nibble <= '0;
    end else begin
      if (cfg.ld_reload) begin
        reload <= cfg.data;
      end
      if (cfg.ld_ctrl) begin
        nibble <= cfg.data[crtb_pkg::NIBBLE_W-1:0];
        count  <= reload;
      end else begin
        count <= count_next;
      end
    end
  end

endmodule

### src/crtb_outbuf.sv
module crtb_outbuf #(
  parameter int W = crtb_pkg::OUT_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] d0;
  logic [W-1:0] d1;
  logic [1:0]   fill;
  logic         push;
  logic         pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = d0;
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (fill == 2'd2) begin
        d0 <= d1;
        if (push) begin
          d1 <= in_data;
        end
      end else if (push) begin
        d0 <= in_data;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        d0 <= in_data;
      end else begin
        d1 <= in_data;
      end
    end
  end

endmodule

### src/cascaded_reload_timer_bank_top.sv
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tick, master_irq_enable
// m_axis   out  m_axis_tvalid/m_axis_tready    overflow_mask, irq_mask, count_zero..three
// cfg      in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// One beat per cycle while s_axis_tready is high: a tick is applied the cycle it
// is accepted and its result is registered into a two-entry output buffer.
// The overflow carry ripples through the timer cells within that cycle.
// s_axis_tready drops only while both buffer entries wait on m_axis.
// rst (synchronous) clears counters, reloads, control and prescaler.
module cascaded_reload_timer_bank_top #(
  parameter int NUM_TIMERS = crtb_pkg::NUM_TIMERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] tick, [1] master_irq_enable, [7:2] zero
  input  logic [crtb_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] overflow_mask, [7:4] irq_mask, [23:8] count_zero,
  // [39:24] count_one, [55:40] count_two, [71:56] count_three
  output logic [crtb_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crtb_pkg::COUNT_W-1:0]    cfg_data
);

  localparam int S = crtb_pkg::TIMER_SLOTS;
  localparam int CW = crtb_pkg::COUNT_W;

  logic [crtb_pkg::PRESCALE_W-1:0] prescale;
  logic [crtb_pkg::PRESCALE_W-1:0] prescale_next;
  logic                            accept;
  logic                            cfg_we;
  crtb_pkg::cell_ctl_t             ctl;
  logic [S:0]                      carry;
  logic [S-1:0]                    ovf;
  logic [S-1:0]                    irq;
  logic [S*CW-1:0]                 counts;
  logic [crtb_pkg::OUT_W-1:0]      result;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign prescale_next = prescale + 1'b1;

  always_comb begin
    ctl.step = accept && s_axis_tdata[0];
    ctl.ime  = s_axis_tdata[1];
    for (int s = 0; s < 2**crtb_pkg::SEL_W; s++) begin
      ctl.hit[s] = ((prescale_next & crtb_pkg::PERIOD_MASK[s]) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= '0;
    end else if (ctl.step) begin
      prescale <= prescale_next;
    end
  end

  assign carry[0] = 1'b0;

  for (genvar i = 0; i < S; i++) begin : g_slot
    if (i < NUM_TIMERS) begin : g_cell
      crtb_pkg::cell_cfg_t cfg;
      always_comb begin
        cfg.ld_reload = cfg_we &&
          (cfg_index == crtb_pkg::CFG_IDX_W'(int'(crtb_pkg::REG_RELOAD_ZERO) + i));
        cfg.ld_ctrl = cfg_we && (cfg_index == crtb_pkg::REG_TIMER_CONTROL);
        // control write hands each cell its own nibble; reload takes the full word
        cfg.data = cfg.ld_ctrl ? (cfg_data >> (crtb_pkg::NIBBLE_W * i)) : cfg_data;
      end
      crtb_cell #(
        .CASCADE_EN (i > 0)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cfg        (cfg),
        .ctl        (ctl),
        .carry_in   (carry[i]),
        .carry_out  (carry[i+1]),
        .irq        (irq[i]),
        .count_next (counts[i*CW +: CW])
      );
      assign ovf[i] = carry[i+1];
    end else begin : g_absent
      assign carry[i+1] = 1'b0;
      assign ovf[i] = 1'b0;
      assign irq[i] = 1'b0;
      assign counts[i*CW +: CW] = '0;
    end
  end

  assign result = {counts, irq, ovf};

  crtb_outbuf #(
    .W (crtb_pkg::OUT_W)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_axis_tready),
    .in_data   (result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### src/crtb_checker.sv
module crtb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [crtb_pkg::OUT_W-1:0]  m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_irq_subset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[7:4] & ~m_axis_tdata[3:0]) == 4'd0))
    else $error("interrupt without overflow");

  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule

bind cascaded_reload_timer_bank_top crtb_checker u_crtb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/cascaded_reload_timer_bank_top_tb.sv
module cascaded_reload_timer_bank_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRESCALE_STOP = 900;

  localparam logic [crtb_pkg::SEL_W-1:0] SEL_DIV1 = 2'd0;
  localparam logic [crtb_pkg::SEL_W-1:0] SEL_DIV64 = 2'd1;
  localparam logic [crtb_pkg::SEL_W-1:0] SEL_DIV256 = 2'd2;
  localparam logic [crtb_pkg::SEL_W-1:0] SEL_DIV1024 = 2'd3;

  localparam int REG_SPARE_LO = int'(crtb_pkg::REG_TIMER_CONTROL) + 1;
  localparam int REG_SPARE_HI = 2**crtb_pkg::CFG_IDX_W - 1;

  typedef struct packed {
    logic [crtb_pkg::TIMER_SLOTS-1:0]                       ovf;
    logic [crtb_pkg::TIMER_SLOTS-1:0]                       irq;
    logic [crtb_pkg::TIMER_SLOTS-1:0][crtb_pkg::COUNT_W-1:0] count;
  } timer_snapshot_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [crtb_pkg::IN_W-1:0]      s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [crtb_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [crtb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [crtb_pkg::COUNT_W-1:0]   cfg_data = '0;

  logic [crtb_pkg::COUNT_W-1:0]    model_reload [crtb_pkg::TIMER_SLOTS];
  logic [crtb_pkg::COUNT_W-1:0]    model_ctrl;
  logic [crtb_pkg::COUNT_W-1:0]    model_count [crtb_pkg::TIMER_SLOTS];
  logic [crtb_pkg::PRESCALE_W-1:0] model_prescale;
  timer_snapshot_t                 snapshots_due [$];
  int                              mismatches = 0;
  int                              stall_left = 0;
  int                              cycles = 0;
  bit                              calm = 1'b0;

  string count_names [crtb_pkg::TIMER_SLOTS] =
    '{"count_zero", "count_one", "count_two", "count_three"};

  cascaded_reload_timer_bank_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("cascaded_reload_timer_bank_top: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [crtb_pkg::NIBBLE_W-1:0] timer_nibble(
    bit run, bit casc, logic [crtb_pkg::SEL_W-1:0] sel);
    logic [crtb_pkg::NIBBLE_W-1:0] n;
    n = '0;
    n[crtb_pkg::SEL_W-1:0] = sel;
    n[crtb_pkg::NIB_CASCADE] = casc;
    n[crtb_pkg::NIB_START] = run;
    return n;
  endfunction

  function automatic void apply_reg_write(logic [crtb_pkg::CFG_IDX_W-1:0] idx,
                                          logic [crtb_pkg::COUNT_W-1:0] data);
    if (idx < crtb_pkg::REG_TIMER_CONTROL) begin
      model_reload[idx[1:0]] = data;
    end else if (idx == crtb_pkg::REG_TIMER_CONTROL) begin
      model_ctrl = data;
      for (int i = 0; i < crtb_pkg::TIMER_SLOTS; i++) model_count[i] = model_reload[i];
    end
  endfunction

  // one system tick through the timer chain, carry ripples upward
  function automatic void advance_timer_model(logic tick, logic ime);
    timer_snapshot_t               snap;
    logic                          carry;
    logic                          bump;
    logic                          wrapped;
    logic [crtb_pkg::NIBBLE_W-1:0] n;
    snap = '0;
    if (tick) begin
      model_prescale = model_prescale + 1'b1;
      carry = 1'b0;
      for (int i = 0; i < crtb_pkg::TIMER_SLOTS; i++) begin
        n = model_ctrl[crtb_pkg::NIBBLE_W*i +: crtb_pkg::NIBBLE_W];
        wrapped = 1'b0;
        if (!n[crtb_pkg::NIB_START]) begin
          bump = 1'b0;
        end else if (i > 0 && n[crtb_pkg::NIB_CASCADE]) begin
          bump = carry;
        end else begin
          bump = (model_prescale & crtb_pkg::PERIOD_MASK[n[crtb_pkg::SEL_W-1:0]]) == '0;
        end
        if (bump) begin
          if (model_count[i] == crtb_pkg::COUNT_MAX) begin
            model_count[i] = model_reload[i];
            wrapped = 1'b1;
            snap.ovf[i] = 1'b1;
            snap.irq[i] = ime;
          end else begin
            model_count[i] = model_count[i] + 1'b1;
          end
        end
        carry = wrapped;
      end
    end
    for (int i = 0; i < crtb_pkg::TIMER_SLOTS; i++) snap.count[i] = model_count[i];
    snapshots_due.push_back(snap);
  endfunction

  function automatic void check_field(string name, logic [crtb_pkg::COUNT_W-1:0] want,
                                      logic [crtb_pkg::COUNT_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %h got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (calm || stall_left == 0) begin
      m_axis_tready <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin : check_beat
    timer_snapshot_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (snapshots_due.size() == 0) begin
        $error("result beat with nothing pending: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = snapshots_due.pop_front();
        check_field("overflow_mask", crtb_pkg::COUNT_W'(want.ovf),
                    crtb_pkg::COUNT_W'(m_axis_tdata[crtb_pkg::TIMER_SLOTS-1:0]));
        check_field("irq_mask", crtb_pkg::COUNT_W'(want.irq),
                    crtb_pkg::COUNT_W'(m_axis_tdata[crtb_pkg::TIMER_SLOTS +:
                                                    crtb_pkg::TIMER_SLOTS]));
        for (int i = 0; i < crtb_pkg::TIMER_SLOTS; i++) begin
          check_field(count_names[i], want.count[i],
                      m_axis_tdata[2*crtb_pkg::TIMER_SLOTS + crtb_pkg::COUNT_W*i +:
                                   crtb_pkg::COUNT_W]);
        end
      end
    end
  end

  // leaves tvalid high after the beat; the caller either sends again or settles
  task automatic send_tick(input logic tick, input logic ime);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(crtb_pkg::IN_W-2){1'b0}}, ime, tick};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_timer_model(tick, ime);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (snapshots_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [crtb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [crtb_pkg::COUNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, data);
  endtask

  task automatic test_reset_state();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    settle();
  endtask

  task automatic test_full_chain();
    for (int r = crtb_pkg::REG_RELOAD_ZERO; r <= crtb_pkg::REG_RELOAD_THREE; r++) begin
      write_reg(crtb_pkg::CFG_IDX_W'(r), crtb_pkg::COUNT_MAX);
    end
    write_reg(crtb_pkg::REG_TIMER_CONTROL,
              {timer_nibble(1, 1, SEL_DIV1), timer_nibble(1, 1, SEL_DIV1),
               timer_nibble(1, 1, SEL_DIV1), timer_nibble(1, 0, SEL_DIV1)});
    cfg_valid <= 1'b0;
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    settle();
    // cascade bit on timer zero has no effect
    write_reg(crtb_pkg::REG_TIMER_CONTROL,
              {timer_nibble(1, 1, SEL_DIV1), timer_nibble(1, 1, SEL_DIV1),
               timer_nibble(1, 1, SEL_DIV1), timer_nibble(1, 1, SEL_DIV1)});
    cfg_valid <= 1'b0;
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_stopped_cascade();
    write_reg(crtb_pkg::REG_TIMER_CONTROL,
              {timer_nibble(1, 1, SEL_DIV1), timer_nibble(0, 1, SEL_DIV1),
               timer_nibble(1, 1, SEL_DIV1), timer_nibble(1, 0, SEL_DIV1)});
    cfg_valid <= 1'b0;
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_reload_write_only();
    write_reg(crtb_pkg::REG_RELOAD_ZERO, 16'hFFFE);
    write_reg(crtb_pkg::REG_TIMER_CONTROL,
              {timer_nibble(0, 0, SEL_DIV1), timer_nibble(0, 0, SEL_DIV1),
               timer_nibble(0, 0, SEL_DIV1), timer_nibble(1, 0, SEL_DIV1)});
    cfg_valid <= 1'b0;
    send_tick(1'b1, 1'b1);
    settle();
    write_reg(crtb_pkg::REG_RELOAD_ZERO, '0);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_spare_index();
    for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++) begin
      write_reg(crtb_pkg::CFG_IDX_W'(k), crtb_pkg::COUNT_MAX);
    end
    cfg_valid <= 1'b0;
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    settle();
  endtask

  task automatic test_mixed_prescale();
    write_reg(crtb_pkg::REG_RELOAD_ZERO, 16'h1234);
    write_reg(crtb_pkg::REG_RELOAD_ONE, '0);
    write_reg(crtb_pkg::REG_RELOAD_TWO, crtb_pkg::COUNT_MAX);
    write_reg(crtb_pkg::REG_RELOAD_THREE, 16'h5AA5);
    write_reg(crtb_pkg::REG_TIMER_CONTROL,
              {timer_nibble(1, 0, SEL_DIV1024), timer_nibble(1, 0, SEL_DIV256),
               timer_nibble(1, 1, SEL_DIV64), timer_nibble(1, 0, SEL_DIV64)});
    cfg_valid <= 1'b0;
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    settle();
  endtask

  function automatic logic [crtb_pkg::COUNT_W-1:0] pick_reload();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return crtb_pkg::COUNT_MAX;
    if (r < 3) return '0;
    if (r < 7) return crtb_pkg::COUNT_W'($urandom_range(16'hFFC0, 16'hFFFF));
    return crtb_pkg::COUNT_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [crtb_pkg::COUNT_W-1:0] pick_control();
    logic [crtb_pkg::COUNT_W-1:0] c;
    if ($urandom_range(0, 7) == 0) return crtb_pkg::COUNT_W'($urandom_range(0, 16'hFFFF));
    for (int i = 0; i < crtb_pkg::TIMER_SLOTS; i++) begin
      c[crtb_pkg::NIBBLE_W*i +: crtb_pkg::NIBBLE_W] =
        timer_nibble($urandom_range(0, 9) < 8,
                     $urandom_range(0, 9) < 4,
                     ($urandom_range(0, 1) == 0) ? SEL_DIV1
                                                 : crtb_pkg::SEL_W'($urandom_range(0, 3)));
    end
    return c;
  endfunction

  task automatic test_random_phases();
    int len;
    bit pause;
    while (model_prescale < PRESCALE_STOP) begin
      calm = ($urandom_range(0, 4) == 0);
      for (int r = crtb_pkg::REG_RELOAD_ZERO; r <= crtb_pkg::REG_RELOAD_THREE; r++) begin
        if ($urandom_range(0, 5) != 0) write_reg(crtb_pkg::CFG_IDX_W'(r), pick_reload());
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(crtb_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  crtb_pkg::COUNT_W'($urandom_range(0, 16'hFFFF)));
      end
      if ($urandom_range(0, 5) != 0) write_reg(crtb_pkg::REG_TIMER_CONTROL, pick_control());
      cfg_valid <= 1'b0;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250) : $urandom_range(10, 60);
      pause = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len && model_prescale < PRESCALE_STOP; n++) begin
        if (pause && n == len / 2) settle();
        send_tick($urandom_range(0, 99) < 97, 1'($urandom_range(0, 1)));
      end
      settle();
    end
    calm = 1'b0;
  endtask

  // run across the prescaler wrap so the slow periods fire
  task automatic test_prescale_wrap();
    bit wrapped;
    int tail;
    write_reg(crtb_pkg::REG_RELOAD_ZERO, crtb_pkg::COUNT_MAX);
    write_reg(crtb_pkg::REG_RELOAD_ONE, crtb_pkg::COUNT_MAX);
    write_reg(crtb_pkg::REG_RELOAD_TWO, 16'hFFF0);
    write_reg(crtb_pkg::REG_RELOAD_THREE, 16'hFFFF);
    write_reg(crtb_pkg::REG_TIMER_CONTROL,
              {timer_nibble(1, 1, SEL_DIV1), timer_nibble(1, 0, SEL_DIV64),
               timer_nibble(1, 0, SEL_DIV256), timer_nibble(1, 0, SEL_DIV1024)});
    cfg_valid <= 1'b0;
    wrapped = 1'b0;
    tail = 0;
    while (tail < 10) begin
      send_tick($urandom_range(0, 99) < 97, 1'($urandom_range(0, 1)));
      if (model_prescale == '0) wrapped = 1'b1;
      if (wrapped) tail++;
    end
    settle();
  endtask

  initial begin
    for (int i = 0; i < crtb_pkg::TIMER_SLOTS; i++) begin
      model_reload[i] = '0;
      model_count[i] = '0;
    end
    model_ctrl = '0;
    model_prescale = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_full_chain();
    test_stopped_cascade();
    test_reload_write_only();
    test_spare_index();
    test_mixed_prescale();
    test_random_phases();
    test_prescale_wrap();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && snapshots_due.size() == 0) begin
      $display("cascaded_reload_timer_bank_top: match");
    end else begin
      $display("cascaded_reload_timer_bank_top: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
src/crtb_pkg.sv
src/crtb_cell.sv
src/crtb_outbuf.sv
src/cascaded_reload_timer_bank_top.sv
src/crtb_checker.sv
tb/sv/cascaded_reload_timer_bank_top_tb.sv
